/* hdl/psvm_pkg.sv */
// ----------------------------------------------------------------------------
// psvm_pkg
// Shared constants, types and the elaboration-time sine table function for
// the polyphonic sine voice mixer.
// ----------------------------------------------------------------------------
package psvm_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_VOICES      = 13;
  localparam int DEF_SAMPLE_RATE = 44100;
  localparam int DEF_PHASE_BITS  = 32;

  // Port field widths.
  localparam int VOICE_W     = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 17;

  // Arithmetic widths.
  localparam int VOL_W     = 15;
  localparam int ENV_W     = 17;
  localparam int MAG_W     = 15;
  localparam int PV_W      = MAG_W + VOL_W;
  localparam int PROD_W    = PV_W + ENV_W;
  localparam int MIX_SHIFT = 31;

  localparam logic [ENV_W-1:0] ENV_FULL      = ENV_W'(65536);
  localparam logic [VOL_W-1:0] VOL_RESET     = VOL_W'(4096);
  localparam logic [ENV_W-1:0] ENV_STEP_RESET = ENV_W'(1638);

  // Sine table geometry: a quarter wave plus its end point.
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
  localparam int QTR_BITS     = SINE_BITS - 2;
  localparam int SINE_QTR     = SINE_ENTRIES / 4;

  // Semitone ratios 2^(s/12) in Q1.16.
  localparam logic [16:0] SEMI_RATIO [12] = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  // Odd Taylor coefficients of sin, Q30 of a quarter turn.
  localparam longint unsigned K1 = 64'd1686629713;
  localparam longint unsigned K3 = 64'd693598668;
  localparam longint unsigned K5 = 64'd85569306;
  localparam longint unsigned K7 = 64'd5026995;
  localparam longint unsigned K9 = 64'd172272;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_GATE = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MASTER_VOLUME = 1'b0,
    CFG_ENV_STEP      = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic gate_we;
    logic run_start;
    logic run_step;
    logic out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_voice;
    logic pipe_busy;
    logic out_busy;
  } sts_t;

  // Magnitude of the sine at table index k, evaluated only at elaboration.
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned k);
    longint unsigned x;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned r;
    x = (64'(k) << 32) / SINE_ENTRIES;
    t = x & 64'h3FFF_FFFF;
    if (x[30]) begin
      t = (64'd1 << 30) - t;
    end
    t2 = (t * t) >> 30;
    r  = K7 - ((t2 * K9) >> 30);
    r  = K5 - ((t2 * r) >> 30);
    r  = K3 - ((t2 * r) >> 30);
    r  = K1 - ((t2 * r) >> 30);
    r  = (t * r) >> 30;
    r  = (r + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[MAG_W-1:0];
  endfunction

endpackage

/* hdl/polyphonic_sine_voice_mixer.sv */
// A gate beat is taken while idle; a tick runs every voice, drains the multiply
// pipeline and then loads its sample into the output register.
// Throughput: one voice per cycle through the shared multiply-accumulate. A new tick is
// taken only once the last sample is handed off; idle gate beats can follow every cycle.
// Reset (synchronous, rst_n low): all phases, levels and gates clear, volume
// returns to 4096 and the envelope step to 1638, and no sample is pending.
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_mixer
// Equal-tempered sine voices with gated linear envelopes, mixed into one
// saturated 16-bit sample per tick.
// ----------------------------------------------------------------------------
module polyphonic_sine_voice_mixer
  import psvm_pkg::*;
#(
  parameter int VOICES      = DEF_VOICES,
  parameter int SAMPLE_RATE = DEF_SAMPLE_RATE,
  parameter int PHASE_BITS  = DEF_PHASE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // [3:0] voice, [4] key_down, [7:5] zero
  input  logic                   in_tuser,  // [0] operation (0 tick, 1 gate change)
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [SAMPLE_W-1:0]    out_tdata, // [15:0] sample, signed
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // The controller only sees the operation bit of each input beat; the voice
  // number and key state go straight to the datapath, which writes the gate
  // while the controller sits idle. A tick sends the controller through a
  // run that steps one voice per cycle, a drain of the multiply pipeline, and a
  // hand-off into the output register. That register lets a new beat be
  // accepted while the previous sample still waits downstream.
  //
  // Each voice in turn: the envelope is stepped toward full scale or zero,
  // the phase is advanced, and the old phase picks a quarter-wave sine
  // magnitude. Magnitude times volume, then times level, is added to or
  // subtracted from the accumulator according to the half wave. The final
  // sum is scaled by 2^-31 toward zero and clamped to 16 bits.

  ctl_t ctl;
  sts_t sts;

  psvm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_operation (in_tuser),
    .ctl          (ctl),
    .sts          (sts)
  );

  psvm_dp #(
    .VOICES      (VOICES),
    .SAMPLE_RATE (SAMPLE_RATE),
    .PHASE_BITS  (PHASE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .in_voice    (in_tdata[VOICE_W-1:0]),
    .in_key_down (in_tdata[VOICE_W]),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_sample  (out_tdata)
  );

endmodule

/* hdl/psvm_ctrl.sv */
// ----------------------------------------------------------------------------
// psvm_ctrl
// Sequencer for the mixer: takes input beats, runs one voice per cycle
// through the datapath on a tick, waits for the pipeline and hands off the
// sample to the output register.
// ----------------------------------------------------------------------------
module psvm_ctrl
  import psvm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_operation,
  output ctl_t ctl,
  input  sts_t sts
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && op_t'(in_operation) == OP_TICK) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.last_voice) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    ctl.gate_we   = 1'b0;
    ctl.run_start = 1'b0;
    ctl.run_step  = 1'b0;
    ctl.out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        ctl.gate_we   = in_tvalid && op_t'(in_operation) == OP_GATE;
        ctl.run_start = in_tvalid && op_t'(in_operation) == OP_TICK;
      end
      ST_RUN: begin
        ctl.run_step = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        ctl.out_load = !sts.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/psvm_dp.sv */
// ----------------------------------------------------------------------------
// psvm_dp
// Voice state, envelope update, sine lookup, two-step multiply, accumulator,
// final scaling and saturation, configuration registers and output register.
// ----------------------------------------------------------------------------
module psvm_dp
  import psvm_pkg::*;
#(
  parameter int VOICES      = DEF_VOICES,
  parameter int SAMPLE_RATE = DEF_SAMPLE_RATE,
  parameter int PHASE_BITS  = DEF_PHASE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctl_t                       ctl,
  output sts_t                       sts,
  input  logic [VOICE_W-1:0]         in_voice,
  input  logic                       in_key_down,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [SAMPLE_W-1:0]        out_sample
);

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ACC_W  = PROD_W + $clog2(VOICES) + 1;
  localparam int QW     = ACC_W - MIX_SHIFT;
  localparam logic signed [QW-1:0] SMAX = QW'(32767);
  localparam logic signed [QW-1:0] SMIN = -SMAX - QW'(1);

  // Per-voice phase increments, fixed at elaboration.
  logic [PHASE_BITS-1:0] inc_tab [VOICES];
  for (genvar i = 0; i < VOICES; i++) begin : g_inc
    localparam longint unsigned NUM =
      (64'd220 * 64'(SEMI_RATIO[(i + 3) % 12])) << ((i + 3) / 12);
    localparam longint unsigned DEN = 64'(SAMPLE_RATE) << (32 - PHASE_BITS);
    localparam longint unsigned INC = ((NUM << 16) + DEN / 2) / DEN;
    assign inc_tab[i] = PHASE_BITS'(INC);
  end

  // Quarter-wave sine magnitude table.
  logic [MAG_W-1:0] sine_tab [SINE_QTR+1];
  for (genvar j = 0; j <= SINE_QTR; j++) begin : g_sine
    localparam logic [MAG_W-1:0] MAG = sine_mag(j);
    assign sine_tab[j] = MAG;
  end

  // Configuration registers; writes are always taken.
  logic [VOL_W-1:0] vol_r;
  logic [ENV_W-1:0] step_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r  <= VOL_RESET;
      step_r <= ENV_STEP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MASTER_VOLUME: vol_r  <= cfg_data[VOL_W-1:0];
        CFG_ENV_STEP:      step_r <= cfg_data[ENV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Voice state.
  logic [PHASE_BITS-1:0] phase_r   [VOICES];
  logic [PHASE_BITS-1:0] phase_nxt [VOICES];
  logic [ENV_W-1:0]      level_r   [VOICES];
  logic [ENV_W-1:0]      level_nxt [VOICES];
  logic                  gate_r    [VOICES];
  logic                  gate_nxt  [VOICES];
  logic [VIDX_W-1:0]     vcnt_r;
  logic [VIDX_W-1:0]     vcnt_nxt;

  logic [PHASE_BITS-1:0] ph_sel;
  logic [ENV_W-1:0]      lv_sel;
  logic                  gate_sel;
  logic [ENV_W:0]        lv_up;
  logic [ENV_W-1:0]      lv_new;
  logic [SINE_BITS-1:0]  sine_k;
  logic [QTR_BITS:0]     sine_j;

  assign ph_sel   = phase_r[vcnt_r];
  assign lv_sel   = level_r[vcnt_r];
  assign gate_sel = gate_r[vcnt_r];
  assign lv_up    = {1'b0, lv_sel} + {1'b0, step_r};

  // The envelope moves before the sample uses it.
  always_comb begin
    if (gate_sel) begin
      lv_new = (lv_up > {1'b0, ENV_FULL}) ? ENV_FULL : lv_up[ENV_W-1:0];
    end else begin
      lv_new = (lv_sel < step_r) ? '0 : lv_sel - step_r;
    end
  end

  // Fold the table index into the first quarter wave.
  assign sine_k = ph_sel[PHASE_BITS-1 -: SINE_BITS];
  assign sine_j = sine_k[QTR_BITS] ?
                  (QTR_BITS+1)'(SINE_QTR) - {1'b0, sine_k[QTR_BITS-1:0]} :
                  {1'b0, sine_k[QTR_BITS-1:0]};

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      phase_nxt[i] = phase_r[i];
      level_nxt[i] = level_r[i];
      gate_nxt[i]  = gate_r[i];
      if (ctl.run_step && vcnt_r == VIDX_W'(i)) begin
        phase_nxt[i] = phase_r[i] + inc_tab[i];
        level_nxt[i] = lv_new;
      end
      if (ctl.gate_we && 7'(in_voice) == 7'(i)) begin
        gate_nxt[i] = in_key_down;
      end
    end
  end

  always_comb begin
    vcnt_nxt = vcnt_r;
    if (ctl.run_start) begin
      vcnt_nxt = '0;
    end else if (ctl.run_step) begin
      vcnt_nxt = vcnt_r + VIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        phase_r[i] <= '0;
        level_r[i] <= '0;
        gate_r[i]  <= 1'b0;
      end
      vcnt_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      gate_r  <= gate_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

  // Pipeline: index, table read, times volume, times level, accumulate.
  logic                    a_v_r, b_v_r, c_v_r, d_v_r;
  logic                    a_neg_r, b_neg_r, c_neg_r, d_neg_r;
  logic [QTR_BITS:0]       a_j_r;
  logic [ENV_W-1:0]        a_lv_r, b_lv_r, c_lv_r;
  logic [MAG_W-1:0]        b_mag_r;
  logic [PV_W-1:0]         c_pv_r;
  logic [PROD_W-1:0]       d_prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      a_v_r <= ctl.run_step;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_j_r    <= sine_j;
    a_neg_r  <= sine_k[SINE_BITS-1];
    a_lv_r   <= lv_new;
    b_mag_r  <= sine_tab[a_j_r];
    b_neg_r  <= a_neg_r;
    b_lv_r   <= a_lv_r;
    c_pv_r   <= PV_W'(b_mag_r) * PV_W'(vol_r);
    c_neg_r  <= b_neg_r;
    c_lv_r   <= b_lv_r;
    d_prod_r <= PROD_W'(c_pv_r) * PROD_W'(c_lv_r);
    d_neg_r  <= c_neg_r;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.run_start) begin
      acc_nxt = '0;
    end else if (d_v_r) begin
      acc_nxt = d_neg_r ? acc_r - ACC_W'(d_prod_r) : acc_r + ACC_W'(d_prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Divide by 2^31 toward zero, then clamp to 16 bits.
  logic signed [QW-1:0]   q_flr;
  logic signed [QW-1:0]   q_val;
  logic [SAMPLE_W-1:0]    sat;
  logic                   q_round_up;

  assign q_flr      = acc_r[ACC_W-1:MIX_SHIFT];
  assign q_round_up = acc_r[ACC_W-1] && (acc_r[MIX_SHIFT-1:0] != '0);
  assign q_val      = q_flr + QW'(q_round_up);

  always_comb begin
    priority if (q_val > SMAX) begin
      sat = SMAX[SAMPLE_W-1:0];
    end else if (q_val < SMIN) begin
      sat = SMIN[SAMPLE_W-1:0];
    end else begin
      sat = q_val[SAMPLE_W-1:0];
    end
  end

  // Output register.
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_sample_r <= sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_sample = out_sample_r;

  assign sts.last_voice = vcnt_r == VIDX_W'(VOICES - 1);
  assign sts.pipe_busy  = a_v_r | b_v_r | c_v_r | d_v_r;
  assign sts.out_busy   = out_valid_r & ~out_tready;

endmodule

/* hdl/psvm_checker.sv */
// ----------------------------------------------------------------------------
// psvm_assert
// Port-level checks on the mixer's streams, bound to the top level.
// ----------------------------------------------------------------------------
module psvm_assert
  import psvm_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                in_tuser,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [SAMPLE_W-1:0] out_tdata
);

  // A stalled sample stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("sample beat dropped while stalled");

  // A stalled sample keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("sample changed while stalled");

  // A gate change leaves the controller idle, so input stays open.
  a_gate_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> in_tready)
    else $error("input closed after a gate change");

  // A tick keeps the input closed while the voices are mixed.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !in_tready ##1 !in_tready)
    else $error("input reopened during a tick");

endmodule

bind polyphonic_sine_voice_mixer psvm_assert u_psvm_assert (.*);

/* sim/psvm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvm_checker
// Watches every beat of the polyphonic sine voice mixer, keeps its own copy of
// the voice state and settings, predicts each sample and compares it.
// ----------------------------------------------------------------------------
module psvm_checker
  import psvm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [SAMPLE_W-1:0]    out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int          NUM_VOICES   = DEF_VOICES;
  localparam int          REPORT_LIMIT = 20;
  localparam logic [63:0] RATE         = 64'd44100;
  localparam logic [17:0] LEVEL_FULL   = 18'd65536;
  localparam longint      MIX_DIV      = 64'sd2147483648;

  // Odd Taylor terms of a quarter-turn sine in Q30.
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;

  logic [14:0]   volume;
  logic [16:0]   step;
  logic [31:0]   phase_acc [NUM_VOICES];
  logic [31:0]   tuning    [NUM_VOICES];
  logic [16:0]   level     [NUM_VOICES];
  logic          gate      [NUM_VOICES];
  logic [15:0]   expected_samples [$];
  int            errors = 0;

  // Equal-tempered semitone ratio in Q1.16.
  function automatic logic [16:0] semitone(input int s);
    case (s)
      0:       return 17'd65536;
      1:       return 17'd69433;
      2:       return 17'd73562;
      3:       return 17'd77936;
      4:       return 17'd82570;
      5:       return 17'd87480;
      6:       return 17'd92682;
      7:       return 17'd98193;
      8:       return 17'd104032;
      9:       return 17'd110218;
      10:      return 17'd116772;
      default: return 17'd123715;
    endcase
  endfunction

  // Per-tick phase step of a voice; voice 9 lands on 440 Hz.
  function automatic logic [31:0] tuning_word(input int idx);
    int          n;
    logic [63:0] num;
    n   = idx + 3;
    num = (64'd220 * semitone(n % 12)) << (n / 12);
    return 32'(((num << 16) + RATE / 2) / RATE);
  endfunction

  // Signed Q1.15 sine of the table entry that a phase selects.
  function automatic int sine_at(input logic [31:0] p);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    x = {32'd0, p[31:22], 22'd0};
    t = {34'd0, x[29:0]};
    if (x[30]) begin
      t = 64'd1073741824 - t;
    end
    t2 = (t * t) >> 30;
    r  = C7 - ((t2 * C9) >> 30);
    r  = C5 - ((t2 * r) >> 30);
    r  = C3 - ((t2 * r) >> 30);
    r  = C1 - ((t2 * r) >> 30);
    r  = (t * r) >> 30;
    r  = (r + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return x[31] ? -int'(r[14:0]) : int'(r[14:0]);
  endfunction

  // One tick: envelopes move first, then the mix, then the phases advance.
  function automatic logic [15:0] mix_next_sample();
    longint      acc;
    longint      q;
    logic [17:0] lv;
    acc = 0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      lv = {1'b0, level[i]};
      if (gate[i]) begin
        lv = lv + step;
        if (lv > LEVEL_FULL) begin
          lv = LEVEL_FULL;
        end
      end else begin
        lv = (lv < step) ? 18'd0 : lv - step;
      end
      level[i]     = lv[16:0];
      acc          = acc + longint'(sine_at(phase_acc[i])) * longint'(volume) * longint'(lv);
      phase_acc[i] = phase_acc[i] + tuning[i];
    end
    q = acc / MIX_DIV;
    if (q > 32767) begin
      q = 32767;
    end
    if (q < -32768) begin
      q = -32768;
    end
    return q[15:0];
  endfunction

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      volume = VOL_RESET;
      step   = ENV_STEP_RESET;
      for (int i = 0; i < NUM_VOICES; i++) begin
        phase_acc[i] = '0;
        level[i]     = '0;
        gate[i]      = 1'b0;
        tuning[i]    = tuning_word(i);
      end
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MASTER_VOLUME: volume = cfg_data[14:0];
          CFG_ENV_STEP:      step   = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (op_t'(in_tuser) == OP_GATE) begin
          // Gate changes for voices past the last one are dropped.
          if (in_tdata[3:0] < NUM_VOICES) begin
            gate[in_tdata[3:0]] = in_tdata[4];
          end
        end else begin
          expected_samples.push_back(mix_next_sample());
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $error("sample beat %0d arrived with no tick outstanding",
                   $signed(out_tdata));
          end
        end else begin
          want = expected_samples.pop_front();
          if (want !== out_tdata) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $error("sample mismatch: expected %0d, actual %0d",
                     $signed(want), $signed(out_tdata));
            end
          end
        end
      end
    end
    pending    <= expected_samples.size();
    fail_count <= errors;
  end

endmodule

/* sim/polyphonic_sine_voice_mixer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_mixer_tb
// Drives gate and tick beats plus register writes into the voice mixer, lets
// the checker predict and compare every sample, and reports the verdict.
// ----------------------------------------------------------------------------
module polyphonic_sine_voice_mixer_tb;
  import psvm_pkg::*;

  // A gate beat may still be in flight when the last sample lands, so the
  // registers are only touched after a tick's worth of quiet cycles.
  localparam int SETTLE_CYCLES = DEF_VOICES + 8;
  localparam int DRAIN_CYCLES  = 2 * (DEF_VOICES + 6);
  // Long sink hold-off used once to back the mixer up into its input.
  localparam int HOLD_CYCLES   = 400;
  // Cycles without any beat on any channel before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 200;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [SAMPLE_W-1:0]    out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;

  // Control between the source, the sink and the main sequence.
  logic sender_gaps  = 1'b0;
  logic sink_gaps    = 1'b0;
  logic hold_pending = 1'b0;
  int   stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polyphonic_sine_voice_mixer u_top (.*);

  psvm_checker u_check (.*);

  // Offers one beat and holds it until the mixer takes it. The valid stays up
  // afterward so back-to-back beats never drop it; a random gap lowers it.
  task automatic send_beat(input op_t op, input logic [3:0] voice, input logic key);
    in_tuser  <= op;
    in_tdata  <= {3'b000, key, voice};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (sender_gaps && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Mostly ticks and in-range gate changes; a tenth of the gate changes draw
  // from all sixteen voice numbers, some of them past the last voice.
  task automatic send_random_item(input int key_pct);
    op_t        op;
    logic [3:0] voice;
    logic       key;
    op = ($urandom_range(99) < 55) ? OP_TICK : OP_GATE;
    if (op == OP_TICK || $urandom_range(9) == 0) begin
      voice = 4'($urandom_range(15));
    end else begin
      voice = 4'($urandom_range(DEF_VOICES - 1));
    end
    key = ($urandom_range(99) < key_pct);
    send_beat(op, voice, key);
  endtask

  // Waits for every sample to drain, lets any gate beat settle, then writes
  // both registers while keeping the write valid high between them.
  task automatic apply_settings(input logic [14:0] vol, input logic [16:0] env);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_index <= CFG_MASTER_VOLUME;
    cfg_data  <= {2'b00, vol};
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ENV_STEP;
    cfg_data  <= env;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Directed opening at the reset settings: silence, the first and last
  // voice, gate changes past the last voice, attack, release, and ticks that
  // carry arbitrary voice and key bits.
  task automatic run_directed();
    send_beat(OP_TICK, 4'd0, 1'b0);
    send_beat(OP_GATE, 4'd0, 1'b1);
    send_beat(OP_GATE, 4'd12, 1'b1);
    send_beat(OP_GATE, 4'd13, 1'b1);
    send_beat(OP_GATE, 4'd15, 1'b1);
    repeat (4) send_beat(OP_TICK, 4'hF, 1'b1);
    send_beat(OP_GATE, 4'd0, 1'b0);
    send_beat(OP_GATE, 4'd15, 1'b0);
    send_beat(OP_TICK, 4'd5, 1'b0);
    send_beat(OP_TICK, 4'd0, 1'b1);
    send_beat(OP_GATE, 4'd12, 1'b0);
    repeat (3) send_beat(OP_TICK, 4'd10, 1'b0);
  endtask

  // Sink side: random ready bursts, plus one long hold-off on request while
  // the source keeps pushing ticks.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_gaps && $urandom_range(2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Hang detection: any accepted beat on any channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("polyphonic_sine_voice_mixer_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int          key_pct;
    logic [14:0] vol;
    logic [16:0] env;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MASTER_VOLUME;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // Each phase picks a setting and a key-down bias. The early ones hit the
    // register extremes: full volume with a full-scale step drives the mix
    // into saturation, a zero step freezes the envelopes, and a step above
    // full scale clamps at once. The last phase runs with no gaps at all.
    for (int ph = 0; ph < PHASES; ph++) begin
      vol     = VOL_RESET;
      env     = ENV_STEP_RESET;
      key_pct = 60;
      case (ph)
        1: begin
          vol     = 15'd32767;
          env     = 17'd65536;
          key_pct = 85;
        end
        2: begin
          vol     = 15'd0;
          env     = 17'd0;
          key_pct = 50;
        end
        3: begin
          vol     = 15'd32767;
          env     = 17'd131071;
          key_pct = 40;
        end
        4: begin
          vol     = 15'd1;
          env     = 17'd1;
          key_pct = 70;
        end
        5: begin
          vol = 15'd12000;
          env = 17'd300;
        end
        6: begin
          vol     = 15'($urandom_range(32767));
          env     = 17'($urandom_range(1, 4096));
          key_pct = $urandom_range(20, 90);
        end
        7: begin
          vol     = 15'd32767;
          env     = 17'd65536;
          key_pct = 90;
        end
        default: ;
      endcase
      if (ph != 0) begin
        apply_settings(vol, env);
      end
      sender_gaps = (ph != PHASES - 1);
      sink_gaps   = (ph != PHASES - 1);
      if (ph == 5) begin
        hold_pending = 1'b1;
      end
      repeat (PHASE_ITEMS) send_random_item(key_pct);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("polyphonic_sine_voice_mixer_tb: PASS");
    end else begin
      $display("polyphonic_sine_voice_mixer_tb: FAIL");
    end
    $finish;
  end

endmodule
